/* src/qsvge_pkg.sv */
// Package for the qubit state-vector gate engine.
// Holds the request and response payload types, operation codes, gate
// register indexes and the sequencer state type. Depends on nothing.
package qsvge_pkg;

  typedef enum logic [2:0] {
    OP_INIT    = 3'd0,
    OP_LOAD    = 3'd1,
    OP_GATE    = 3'd2,
    OP_CNOT    = 3'd3,
    OP_MEASURE = 3'd4,
    OP_READ    = 3'd5
  } op_code_t;

  localparam int NUM_GATE_REGS = 8;
  localparam logic [2:0] REG_G00_RE = 3'd0;
  localparam logic [2:0] REG_G11_RE = 3'd6;
  localparam logic signed [15:0] Q14_ONE = 16'sd16384;

  typedef struct packed {
    logic [2:0]         op;
    logic [9:0]         index;
    logic [3:0]         target_qubit;
    logic [3:0]         control_qubit;
    logic signed [15:0] in_re;
    logic signed [15:0] in_im;
    logic [15:0]        random_fraction;
  } in_item_t;

  typedef struct packed {
    logic [9:0]         out_index;
    logic signed [15:0] out_re;
    logic signed [15:0] out_im;
    logic               status;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RESP,
    ST_R_A,
    ST_R_B,
    ST_G_RA,
    ST_G_RB,
    ST_G_RC,
    ST_G_MAC,
    ST_G_W0,
    ST_G_W1,
    ST_M_RD,
    ST_M_SQR,
    ST_M_SQI,
    ST_M_ADD,
    ST_M_THR
  } state_t;

endpackage

/* src/qubit_state_vector_gate_engine_top.sv */
// Qubit state-vector gate engine: top level with amplitude memory and sequencer.
// Uses qsvge_pkg for payload types, operation codes and state type.
//
// The block holds 2^NUM_QUBITS complex amplitudes in a single-port-write,
// single-port-read memory and takes one request at a time; in_ready is high
// only while idle. After reset a clearing pass writes basis state zero, during
// which no request is taken; init repeats that pass. A gate walks the D/2 pairs,
// D = 2^NUM_QUBITS (each pair takes two reads, sixteen passes through the one
// shared multiplier and two writes), CNOT swaps only the pairs whose control bit
// is set, and measure makes two passes over the entries (read, square the real
// part, square the imaginary part, add; the second pass stops at the outcome),
// with a 16-step shift-add threshold between them, then a collapse sweep.
// Every request gives one response, held until taken.
module qubit_state_vector_gate_engine_top #(
  parameter int NUM_QUBITS = 10,
  parameter int AMP_WIDTH  = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  qsvge_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output qsvge_pkg::out_item_t out_data,
  input  logic                 cfg_we,
  input  logic [2:0]           cfg_addr,
  input  logic [15:0]          cfg_wdata
);
  import qsvge_pkg::*;

  localparam int DIM  = 1 << NUM_QUBITS;
  localparam int AW   = AMP_WIDTH;
  localparam int MW   = (AW > 16) ? AW : 16;
  localparam int SH   = (2 * AW > 32) ? (2 * AW - 32) : 0;
  localparam int PW   = 2 * AW - SH;
  localparam int TW   = PW + NUM_QUBITS;
  localparam int ACW  = 2 * MW + 2;
  localparam int UP   = (AW >= 16) ? (AW - 16) : 0;
  localparam int DN   = (AW < 16) ? (16 - AW) : 0;
  localparam int RDN  = (1 << DN) >> 1;
  localparam int RUP  = (1 << UP) >> 1;
  localparam int NQ   = NUM_QUBITS;

  // Memory and read port
  logic [2*AW-1:0] mem [DIM];
  logic [2*AW-1:0] rd_data_r;
  logic [NQ-1:0]   rd_addr, wr_addr;
  logic [2*AW-1:0] wr_data;
  logic            wr_en;

  state_t state_r, state_nxt;

  logic signed [15:0] g_r [NUM_GATE_REGS];
  logic [2:0]      op_r;
  logic [NQ-1:0]   idx_r, k_r, cnt_r;
  logic [3:0]      tq_r, cq_r, bit_r;
  logic [15:0]     frac_r;
  logic [2*AW-1:0] x_r, y_r;
  logic [4:0]      step_r;
  logic            pvld_r, pass_r, clr_resp_r;
  logic [3:0]      term_r;
  logic signed [2*MW-1:0] prod_r;
  logic signed [ACW-1:0]  acc_r;
  logic [2*AW-1:0] psum_r;
  logic [AW-1:0]   res_r [4];
  logic [TW-1:0]   tot_r, run_r;
  logic [TW+15:0]  tacc_r;
  out_item_t       out_r;
  logic            out_valid_r;

  // Shared datapath signals
  logic signed [MW-1:0]   mul_a, mul_b;
  logic signed [ACW-1:0]  acc_nxt;
  logic [AW-1:0]          acc_sat;
  logic [2*AW-1:0]        sq_sum;
  logic [PW-1:0]          p_val;
  logic [TW-1:0]          run_nxt, thr;
  logic [TW+15:0]         tacc_nxt;
  logic [NQ-1:0]          low_mask, pair_i, pair_j, pe, idx_in;
  logic                   accept, pair_last, ent_last, t_bad, c_bad, hit;
  logic signed [15:0]     coef;
  logic [2*AW-1:0]        amp_w;
  logic [AW-1:0]          amp_sel;
  logic [1:0]             mo;
  logic [1:0]             mk;

  function automatic logic [AW-1:0] to_amp(input logic signed [15:0] q);
    logic signed [47:0] v;
    v = 48'(q) <<< UP;
    v = (v + 48'(RDN)) >>> DN;
    if (v > 48'sd0 + ((48'sd1 <<< (AW - 1)) - 48'sd1)) begin
      v = (48'sd1 <<< (AW - 1)) - 48'sd1;
    end
    return v[AW-1:0];
  endfunction

  function automatic logic [15:0] from_amp(input logic [AW-1:0] a);
    logic signed [47:0] v;
    v = 48'(signed'(a)) <<< DN;
    v = (v + 48'(RUP)) >>> UP;
    if (v > 48'sd32767) begin
      v = 48'sd32767;
    end else if (v < -48'sd32768) begin
      v = -48'sd32768;
    end
    return v[15:0];
  endfunction

  function automatic logic [AW-1:0] sat_amp(input logic signed [ACW-1:0] s);
    logic signed [ACW-1:0] r, hi, lo;
    r  = (s + ACW'(8192)) >>> 14;
    hi = (ACW'(1) <<< (AW - 1)) - ACW'(1);
    lo = -hi - ACW'(1);
    if (r > hi) begin
      r = hi;
    end else if (r < lo) begin
      r = lo;
    end
    return r[AW-1:0];
  endfunction

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign idx_in    = NQ'(in_data.index);
  assign t_bad     = 32'(in_data.target_qubit) >= NUM_QUBITS;
  assign c_bad     = 32'(in_data.control_qubit) >= NUM_QUBITS;

  // Pair addressing: insert a zero at the target bit of the pair counter.
  always_comb begin
    pe       = {1'b0, cnt_r[NQ-2:0]};
    low_mask = (NQ'(1) << tq_r) - NQ'(1);
    pair_i   = ((pe & ~low_mask) << 1) | (pe & low_mask);
    pair_j   = pair_i | (NQ'(1) << tq_r);
  end
  assign pair_last = &cnt_r[NQ-2:0];
  assign ent_last  = &cnt_r;

  // Shared multiplier operand selection
  always_comb begin
    mo      = step_r[3:2];
    mk      = step_r[1:0];
    coef    = g_r[{mo[1], mk}];
    amp_w   = mk[1] ? y_r : x_r;
    amp_sel = (mk[0] ^ mo[0]) ? amp_w[2*AW-1:AW] : amp_w[AW-1:0];
    mul_a   = MW'(coef);
    mul_b   = MW'(signed'(amp_sel));
    case (state_r)
      ST_M_SQR: begin
        mul_a = MW'(signed'(rd_data_r[AW-1:0]));
        mul_b = MW'(signed'(rd_data_r[AW-1:0]));
      end
      ST_M_SQI: begin
        mul_a = MW'(signed'(rd_data_r[2*AW-1:AW]));
        mul_b = MW'(signed'(rd_data_r[2*AW-1:AW]));
      end
      default: ;
    endcase
  end

  // Accumulate, probability and threshold arithmetic
  always_comb begin
    // The sign flag of the term in flight: real parts subtract the odd terms.
    if (!term_r[2] && term_r[0]) begin
      acc_nxt = acc_r - ACW'(prod_r);
    end else begin
      acc_nxt = acc_r + ACW'(prod_r);
    end
    acc_sat  = sat_amp(acc_nxt);
    sq_sum   = psum_r + prod_r[2*AW-1:0];
    p_val    = PW'(sq_sum >> SH);
    run_nxt  = run_r + TW'(p_val);
    thr      = TW'(tacc_r >> 16);
    hit      = run_nxt > thr;
    tacc_nxt = (tacc_r << 1) + (frac_r[bit_r] ? (TW + 16)'(tot_r) : '0);
  end

  // Memory port controls
  always_comb begin
    rd_addr = pair_i;
    wr_en   = 1'b0;
    wr_addr = cnt_r;
    wr_data = '0;
    case (state_r)
      ST_IDLE: begin
        wr_en   = accept && (in_data.op == OP_LOAD);
        wr_addr = idx_in;
        wr_data = {to_amp(in_data.in_im), to_amp(in_data.in_re)};
      end
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = (cnt_r == k_r) ? (2*AW)'(1 << (AW - 2)) : '0;
      end
      ST_R_A:   rd_addr = idx_r;
      ST_G_RB:  rd_addr = pair_j;
      ST_M_RD, ST_M_SQR: rd_addr = cnt_r;
      ST_G_W0: begin
        wr_en   = 1'b1;
        wr_addr = pair_i;
        wr_data = (op_r == OP_CNOT) ? y_r : {res_r[1], res_r[0]};
      end
      ST_G_W1: begin
        wr_en   = 1'b1;
        wr_addr = pair_j;
        wr_data = (op_r == OP_CNOT) ? x_r : {res_r[3], res_r[2]};
      end
      default: ;
    endcase
  end

  // Read data is registered and appears in the cycle after its address.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (ent_last) state_nxt = clr_resp_r ? ST_RESP : ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          case (in_data.op)
            OP_INIT:    state_nxt = ST_CLEAR;
            OP_LOAD:    state_nxt = ST_RESP;
            OP_GATE:    state_nxt = t_bad ? ST_RESP : ST_G_RA;
            OP_CNOT: begin
              if (t_bad || c_bad || in_data.target_qubit == in_data.control_qubit) begin
                state_nxt = ST_RESP;
              end else begin
                state_nxt = ST_G_RA;
              end
            end
            OP_MEASURE: state_nxt = ST_M_RD;
            OP_READ:    state_nxt = ST_R_A;
            default:    state_nxt = ST_RESP;
          endcase
        end
      end
      ST_RESP:  if (out_ready) state_nxt = ST_IDLE;
      ST_R_A:   state_nxt = ST_R_B;
      ST_R_B:   state_nxt = ST_RESP;
      ST_G_RA:  state_nxt = ST_G_RB;
      ST_G_RB:  state_nxt = ST_G_RC;
      ST_G_RC: begin
        if (op_r != OP_CNOT) begin
          state_nxt = ST_G_MAC;
        end else if (pair_i[cq_r]) begin
          state_nxt = ST_G_W0;
        end else begin
          state_nxt = pair_last ? ST_RESP : ST_G_RA;
        end
      end
      ST_G_MAC: if (step_r == 5'd16) state_nxt = ST_G_W0;
      ST_G_W0:  state_nxt = ST_G_W1;
      ST_G_W1:  state_nxt = pair_last ? ST_RESP : ST_G_RA;
      ST_M_RD:  state_nxt = ST_M_SQR;
      ST_M_SQR: state_nxt = ST_M_SQI;
      ST_M_SQI: state_nxt = ST_M_ADD;
      ST_M_ADD: begin
        if (!pass_r) begin
          state_nxt = ent_last ? ST_M_THR : ST_M_RD;
        end else if (hit || ent_last) begin
          state_nxt = ST_CLEAR;
        end else begin
          state_nxt = ST_M_RD;
        end
      end
      ST_M_THR: if (bit_r == 4'd0) state_nxt = ST_M_RD;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      k_r         <= '0;
      clr_resp_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pvld_r      <= 1'b0;
      for (int n = 0; n < NUM_GATE_REGS; n++) begin
        g_r[n] <= '0;
      end
      g_r[REG_G00_RE] <= Q14_ONE;
      g_r[REG_G11_RE] <= Q14_ONE;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= (state_nxt == ST_RESP);
      if (cfg_we) begin
        g_r[cfg_addr] <= signed'(cfg_wdata);
      end
      pvld_r <= (state_r == ST_G_MAC) && (step_r != 5'd16);
      case (state_r)
        ST_CLEAR: cnt_r <= cnt_r + NQ'(1);
        ST_IDLE: begin
          cnt_r <= '0;
          if (accept) begin
            k_r        <= '0;
            clr_resp_r <= 1'b1;
          end
        end
        ST_G_RC: begin
          if (op_r == OP_CNOT && !pair_i[cq_r]) cnt_r <= cnt_r + NQ'(1);
        end
        ST_G_W1: cnt_r <= cnt_r + NQ'(1);
        ST_M_ADD: begin
          cnt_r <= cnt_r + NQ'(1);
          if (pass_r && (hit || ent_last)) begin
            k_r   <= hit ? cnt_r : '0;
            cnt_r <= '0;
          end
        end
        ST_M_THR: cnt_r <= '0;
        default: ;
      endcase
    end
  end

  // Payload and datapath registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (pvld_r) begin
      if (term_r[1:0] == 2'd3) begin
        res_r[term_r[3:2]] <= acc_sat;
        acc_r <= '0;
      end else begin
        acc_r <= acc_nxt;
      end
    end
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          op_r   <= in_data.op;
          idx_r  <= idx_in;
          tq_r   <= in_data.target_qubit;
          cq_r   <= in_data.control_qubit;
          frac_r <= in_data.random_fraction;
          pass_r <= 1'b0;
          tot_r  <= '0;
          run_r  <= '0;
          out_r  <= '0;
          case (in_data.op)
            OP_GATE: out_r.status <= t_bad;
            OP_CNOT: out_r.status <= t_bad || c_bad ||
                                     (in_data.target_qubit == in_data.control_qubit);
            OP_INIT, OP_LOAD, OP_MEASURE, OP_READ: ;
            default: out_r.status <= 1'b1;
          endcase
        end
      end
      ST_R_B: begin
        out_r.out_index <= 10'(idx_r);
        out_r.out_re    <= signed'(from_amp(rd_data_r[AW-1:0]));
        out_r.out_im    <= signed'(from_amp(rd_data_r[2*AW-1:AW]));
      end
      ST_G_RB: x_r <= rd_data_r;
      ST_G_RC: begin
        y_r    <= rd_data_r;
        step_r <= '0;
        acc_r  <= '0;
      end
      ST_G_MAC: begin
        if (step_r != 5'd16) begin
          term_r <= step_r[3:0];
          step_r <= step_r + 5'd1;
        end
      end
      ST_M_SQI: psum_r <= prod_r[2*AW-1:0];
      ST_M_ADD: begin
        if (!pass_r) begin
          tot_r <= tot_r + TW'(p_val);
          bit_r <= 4'd15;
          tacc_r <= '0;
        end else begin
          run_r <= run_nxt;
          if (hit || ent_last) begin
            out_r.out_index <= hit ? 10'(cnt_r) : 10'd0;
          end
        end
      end
      ST_M_THR: begin
        tacc_r <= tacc_nxt;
        bit_r  <= bit_r - 4'd1;
        if (bit_r == 4'd0) pass_r <= 1'b1;
      end
      default: ;
    endcase
  end

`ifndef ASSERT_OFF
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("request taken while response pending");
  a_mac_src: assert property (@(posedge clk) disable iff (!rst_n)
    pvld_r |-> $past(state_r) == ST_G_MAC) else $error("product outside MAC phase");
  a_w1_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_G_W1 |-> $past(state_r) == ST_G_W0) else $error("pair write order");
  a_resp_done: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> state_r == ST_IDLE) else $error("response dropped early");
`endif

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the qubit state-vector gate engine.
// It keeps its own copy of the amplitude vector and gate matrix, predicts every response,
// and checks it against the block. It depends on qsvge_pkg and qubit_state_vector_gate_engine_top.
`timescale 1ns / 100ps

module tb_top;
  import qsvge_pkg::*;

  localparam int DIM = 1024;
  localparam logic [2:0] OP_BAD6 = 3'd6;
  localparam logic [2:0] OP_BAD7 = 3'd7;
  localparam int HOLD_CYCLES = 600;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_we;
  logic [2:0] cfg_addr;
  logic [15:0] cfg_wdata;

  qubit_state_vector_gate_engine_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  // Predictor state: the amplitude vector and the gate matrix.
  logic signed [15:0] sv_re [DIM];
  logic signed [15:0] sv_im [DIM];
  logic signed [15:0] gate_coef [8];

  in_item_t pending_req_q [$];
  out_item_t expected_resp_q [$];
  int fail_count;
  logic hold_go;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #64000000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic void set_basis_zero();
    for (int i = 0; i < DIM; i++) begin
      sv_re[i] = '0;
      sv_im[i] = '0;
    end
    sv_re[0] = Q14_ONE;
  endfunction

  function automatic logic signed [15:0] round_sat(longint s);
    longint r;
    r = (s + 64'sd8192) >>> 14;
    if (r > 32767) return 16'sh7fff;
    if (r < -32768) return 16'sh8000;
    return r[15:0];
  endfunction

  function automatic void apply_gate(int t);
    longint xr, xi, yr, yi;
    longint g [8];
    int j;
    for (int k = 0; k < 8; k++) g[k] = gate_coef[k];
    for (int i = 0; i < DIM; i++) begin
      if (((i >> t) & 1) == 0) begin
        j = i | (1 << t);
        xr = sv_re[i]; xi = sv_im[i]; yr = sv_re[j]; yi = sv_im[j];
        sv_re[i] = round_sat(g[0]*xr - g[1]*xi + g[2]*yr - g[3]*yi);
        sv_im[i] = round_sat(g[0]*xi + g[1]*xr + g[2]*yi + g[3]*yr);
        sv_re[j] = round_sat(g[4]*xr - g[5]*xi + g[6]*yr - g[7]*yi);
        sv_im[j] = round_sat(g[4]*xi + g[5]*xr + g[6]*yi + g[7]*yr);
      end
    end
  endfunction

  function automatic void apply_cnot(int c, int t);
    logic signed [15:0] r, m;
    int j;
    for (int i = 0; i < DIM; i++) begin
      if ((((i >> c) & 1) == 1) && (((i >> t) & 1) == 0)) begin
        j = i | (1 << t);
        r = sv_re[i]; m = sv_im[i];
        sv_re[i] = sv_re[j]; sv_im[i] = sv_im[j];
        sv_re[j] = r; sv_im[j] = m;
      end
    end
  endfunction

  function automatic longint unsigned amp_prob(int i);
    longint r, m;
    r = sv_re[i];
    m = sv_im[i];
    return longint'(r * r + m * m);
  endfunction

  function automatic int measure_outcome(logic [15:0] frac);
    longint unsigned total, acc, thr;
    int outcome;
    total = 0; acc = 0; outcome = 0;
    for (int i = 0; i < DIM; i++) total += amp_prob(i);
    thr = (total >> 16) * frac + (((total & 64'hffff) * frac) >> 16);
    for (int i = 0; i < DIM; i++) begin
      acc += amp_prob(i);
      if (acc > thr) begin
        outcome = i;
        break;
      end
    end
    set_basis_zero();
    sv_re[0] = '0;
    sv_re[outcome] = Q14_ONE;
    return outcome;
  endfunction

  function automatic out_item_t predict_response(in_item_t rq);
    out_item_t rs;
    int t, c, m;
    rs = '0;
    t = rq.target_qubit;
    c = rq.control_qubit;
    case (rq.op)
      OP_INIT: set_basis_zero();
      OP_LOAD: begin
        sv_re[rq.index] = rq.in_re;
        sv_im[rq.index] = rq.in_im;
      end
      OP_GATE: begin
        if (t >= 10) rs.status = 1'b1;
        else apply_gate(t);
      end
      OP_CNOT: begin
        if (t >= 10 || c >= 10 || c == t) rs.status = 1'b1;
        else apply_cnot(c, t);
      end
      OP_MEASURE: begin
        m = measure_outcome(rq.random_fraction);
        rs.out_index = m[9:0];
      end
      OP_READ: begin
        rs.out_index = rq.index;
        rs.out_re = sv_re[rq.index];
        rs.out_im = sv_im[rq.index];
      end
      default: rs.status = 1'b1;
    endcase
    return rs;
  endfunction

  function automatic in_item_t make_req(logic [2:0] op, logic [9:0] idx, logic [3:0] t,
                                        logic [3:0] c, logic [15:0] re, logic [15:0] im,
                                        logic [15:0] frac);
    in_item_t rq;
    rq.op = op; rq.index = idx; rq.target_qubit = t; rq.control_qubit = c;
    rq.in_re = re; rq.in_im = im; rq.random_fraction = frac;
    return rq;
  endfunction

  // Mostly well-formed operations on in-range qubits, with some rejected ones mixed in.
  function automatic in_item_t random_req();
    in_item_t rq;
    int pick;
    rq = in_item_t'({$urandom, $urandom, $urandom});
    rq.target_qubit = $urandom_range(0, 9);
    rq.control_qubit = $urandom_range(0, 9);
    pick = $urandom_range(0, 99);
    if (pick < 30) rq.op = OP_LOAD;
    else if (pick < 52) rq.op = OP_READ;
    else if (pick < 62) rq.op = OP_GATE;
    else if (pick < 73) rq.op = OP_CNOT;
    else if (pick < 81) rq.op = OP_MEASURE;
    else if (pick < 86) rq.op = OP_INIT;
    else if (pick < 89) rq.op = ($urandom_range(0, 1) != 0) ? OP_BAD6 : OP_BAD7;
    else if (pick < 94) begin
      rq.op = ($urandom_range(0, 1) != 0) ? OP_GATE : OP_CNOT;
      rq.target_qubit = $urandom_range(0, 15);
      rq.control_qubit = $urandom_range(0, 15);
    end else rq.op = OP_READ;
    return rq;
  endfunction

  // Request driver: bursts of random length separated by random gaps.
  int burst_left;
  int gap_left;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 1;
      gap_left <= 0;
    end else begin
      if (in_valid && in_ready) expected_resp_q.push_back(predict_response(in_data));
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_req_q.size() > 0) begin
          in_data <= pending_req_q.pop_front();
          in_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Response side: its own stall pattern, plus one long hold-off when asked for.
  int cyc;
  int hold_left;
  logic hold_done;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      cyc <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      cyc <= cyc + 1;
      if (hold_go && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (cyc[9]) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ((cyc % 11) < 7) && ($urandom_range(0, 3) != 0);
      end
    end
  end

  // Response checker.
  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_resp_q.size() == 0) begin
        $display("%0t: response with none expected: %h", $realtime, out_data);
        fail_count++;
      end else begin
        want = expected_resp_q.pop_front();
        if (out_data.out_index !== want.out_index) begin
          $display("%0t: out_index expected %0d actual %0d", $realtime,
                   want.out_index, out_data.out_index);
          fail_count++;
        end
        if (out_data.out_re !== want.out_re) begin
          $display("%0t: out_re expected %0d actual %0d", $realtime,
                   want.out_re, out_data.out_re);
          fail_count++;
        end
        if (out_data.out_im !== want.out_im) begin
          $display("%0t: out_im expected %0d actual %0d", $realtime,
                   want.out_im, out_data.out_im);
          fail_count++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime,
                   want.status, out_data.status);
          fail_count++;
        end
      end
    end
  end

  task automatic wait_drained();
    while (pending_req_q.size() != 0 || in_valid || expected_resp_q.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_gate(input logic signed [15:0] g [8]);
    for (int k = 0; k < 8; k++) begin
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_addr <= k[2:0];
      cfg_wdata <= g[k];
      gate_coef[k] = g[k];
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic push_random(int n);
    for (int k = 0; k < n; k++) pending_req_q.push_back(random_req());
  endtask

  initial begin
    logic signed [15:0] g [8];
    fail_count = 0;
    hold_go = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    for (int k = 0; k < 8; k++) gate_coef[k] = '0;
    gate_coef[REG_G00_RE] = Q14_ONE;
    gate_coef[REG_G11_RE] = Q14_ONE;
    set_basis_zero();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part with the reset gate matrix.
    pending_req_q.push_back(make_req(OP_READ, 10'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0));
    pending_req_q.push_back(make_req(OP_LOAD, 10'd1023, 4'd0, 4'd0, 16'h7fff, 16'h8000,
                                     16'h0));
    pending_req_q.push_back(make_req(OP_LOAD, 10'd512, 4'd0, 4'd0, 16'h8000, 16'h7fff,
                                     16'hffff));
    pending_req_q.push_back(make_req(OP_READ, 10'd1023, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0));
    pending_req_q.push_back(make_req(OP_GATE, 10'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0));
    pending_req_q.push_back(make_req(OP_GATE, 10'd0, 4'd9, 4'd0, 16'h0, 16'h0, 16'h0));
    pending_req_q.push_back(make_req(OP_GATE, 10'd0, 4'd10, 4'd0, 16'h0, 16'h0, 16'h0));
    pending_req_q.push_back(make_req(OP_GATE, 10'd0, 4'd15, 4'd0, 16'h0, 16'h0, 16'h0));
    pending_req_q.push_back(make_req(OP_CNOT, 10'd0, 4'd3, 4'd3, 16'h0, 16'h0, 16'h0));
    pending_req_q.push_back(make_req(OP_CNOT, 10'd0, 4'd2, 4'd10, 16'h0, 16'h0, 16'h0));
    pending_req_q.push_back(make_req(OP_CNOT, 10'd0, 4'd15, 4'd1, 16'h0, 16'h0, 16'h0));
    pending_req_q.push_back(make_req(OP_CNOT, 10'd0, 4'd0, 4'd9, 16'h0, 16'h0, 16'h0));
    pending_req_q.push_back(make_req(OP_READ, 10'd511, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0));
    pending_req_q.push_back(make_req(OP_MEASURE, 10'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0));
    pending_req_q.push_back(make_req(OP_LOAD, 10'd7, 4'd0, 4'd0, 16'h2000, 16'h2000, 16'h0));
    pending_req_q.push_back(make_req(OP_MEASURE, 10'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'hffff));
    pending_req_q.push_back(make_req(OP_BAD6, 10'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0));
    pending_req_q.push_back(make_req(OP_BAD7, 10'h3ff, 4'hf, 4'hf, 16'hffff, 16'hffff,
                                     16'hffff));
    // An all-zero vector must measure as outcome zero.
    pending_req_q.push_back(make_req(OP_LOAD, 10'd7, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0));
    pending_req_q.push_back(make_req(OP_MEASURE, 10'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h8000));
    pending_req_q.push_back(make_req(OP_READ, 10'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0));
    pending_req_q.push_back(make_req(OP_INIT, 10'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0));
    pending_req_q.push_back(make_req(OP_READ, 10'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0));
    wait_drained();

    // Hadamard; the receiver holds off for a long stretch while requests keep coming.
    g = '{16'sd11585, 16'sd0, 16'sd11585, 16'sd0, 16'sd11585, 16'sd0, -16'sd11585, 16'sd0};
    write_gate(g);
    @(negedge clk);
    hold_go = 1'b1;
    push_random(100);
    wait_drained();

    // Extreme coefficients drive the gate sums into saturation.
    g = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
          16'sh8000};
    write_gate(g);
    pending_req_q.push_back(make_req(OP_LOAD, 10'd0, 4'd0, 4'd0, 16'h7fff, 16'h8000, 16'h0));
    pending_req_q.push_back(make_req(OP_LOAD, 10'd1, 4'd0, 4'd0, 16'h8000, 16'h8000, 16'h0));
    pending_req_q.push_back(make_req(OP_GATE, 10'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0));
    pending_req_q.push_back(make_req(OP_READ, 10'd0, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0));
    pending_req_q.push_back(make_req(OP_READ, 10'd1, 4'd0, 4'd0, 16'h0, 16'h0, 16'h0));
    push_random(55);
    wait_drained();

    for (int k = 0; k < 8; k++) g[k] = $urandom;
    write_gate(g);
    push_random(55);
    wait_drained();

    // Pauli Y exercises the imaginary coefficients.
    g = '{16'sd0, 16'sd0, 16'sd0, -16'sd16384, 16'sd0, 16'sd16384, 16'sd0, 16'sd0};
    write_gate(g);
    push_random(70);
    wait_drained();
    repeat (50) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
